/* src/pps_pkg.sv */
// pps_pkg: shared constants and types for the preemptive priority scheduler
// no dependencies; imported by every module of the block
`default_nettype none

package pps_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TASK_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int TIME_W    = 17;
  localparam int OUT_IDX_W = 4;
  localparam int PRIO_W    = 8;
  localparam int BURST_W   = 8;
  localparam int ARR_W     = 16;

  // one stored task
  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] remain;
  } task_rec_t;

  // scan control from the sequencer to the pick unit
  typedef struct packed {
    logic              clear;
    logic              cmp;
    logic [TASK_W-1:0] idx;
  } scan_ctl_t;

  // pick unit result after a full scan
  typedef struct packed {
    logic              found;
    logic [TASK_W-1:0] idx;
    task_rec_t         rec;
    logic [ARR_W-1:0]  min_arrival;
  } pick_t;

endpackage

`default_nettype wire

/* src/pps_task_mem.sv */
// pps_task_mem: task table, one write port and one registered read port
// depends on pps_pkg
`default_nettype none

module pps_task_mem (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [pps_pkg::TASK_W-1:0] waddr,
  input  wire pps_pkg::task_rec_t        wdata,
  input  wire logic [pps_pkg::TASK_W-1:0] raddr,
  output pps_pkg::task_rec_t             rdata
);
  import pps_pkg::*;

  task_rec_t mem [MAX_TASKS];
  task_rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* src/pps_pick.sv */
// pps_pick: running selection over the task table, one entry per cycle
// depends on pps_pkg; fed by pps_task_mem read data
`default_nettype none

module pps_pick (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire pps_pkg::scan_ctl_t         ctl,
  input  wire pps_pkg::task_rec_t         rec,
  input  wire logic [pps_pkg::TIME_W-1:0] sim_time,
  output pps_pkg::pick_t                  pick
);
  import pps_pkg::*;

  logic              found_r;
  logic [TASK_W-1:0] idx_r;
  task_rec_t         rec_r;
  logic [PRIO_W:0]   best_prio_r;
  logic [ARR_W-1:0]  min_arr_r;
  logic              ready;

  assign ready = (rec.remain != '0) &&
                 ({{(TIME_W-ARR_W){1'b0}}, rec.arrival} <= sim_time);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clear) begin
      found_r <= 1'b0;
    end else if (ctl.cmp && ready && ({1'b0, rec.prio} < best_prio_r)) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      best_prio_r <= {1'b1, {PRIO_W{1'b0}}};
      min_arr_r   <= '1;
    end else if (ctl.cmp) begin
      if (ready && ({1'b0, rec.prio} < best_prio_r)) begin
        best_prio_r <= {1'b0, rec.prio};
        idx_r       <= ctl.idx;
        rec_r       <= rec;
      end
      // earliest arrival among unfinished tasks, for skipping idle ticks
      if ((rec.remain != '0) && (rec.arrival < min_arr_r)) begin
        min_arr_r <= rec.arrival;
      end
    end
  end

  always_comb begin
    pick.found       = found_r;
    pick.idx         = idx_r;
    pick.rec         = rec_r;
    pick.min_arrival = min_arr_r;
  end

endmodule

`default_nettype wire

/* src/preemptive_priority_scheduler.sv */
// preemptive_priority_scheduler: top level, load sequencer and tick loop
// depends on pps_pkg, pps_task_mem and pps_pick
//
//   channel   ports                                   handshake
//   load      in_burst_ticks in_task_priority         start & !busy
//             in_arrival_tick in_last_task
//   result    out_task_index out_wait_ticks           out_strobe, one cycle
//             out_turnaround_ticks out_last_done
//
// the last load starts the run and raises busy
// each tick is a scan of the task table through its single read port, then
// one write-back of the charged task
// a stretch with no ready task is crossed in one tick step
// reset clears counters and state only; no clearing pass over the table
// results cannot be stalled; busy falls as the last result is shown
`default_nettype none

module preemptive_priority_scheduler (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [pps_pkg::BURST_W-1:0]     in_burst_ticks,
  input  wire logic [pps_pkg::PRIO_W-1:0]      in_task_priority,
  input  wire logic [pps_pkg::ARR_W-1:0]       in_arrival_tick,
  input  wire logic                            in_last_task,
  output logic                                 out_strobe,
  output logic [pps_pkg::OUT_IDX_W-1:0]        out_task_index,
  output logic [pps_pkg::TIME_W-1:0]           out_wait_ticks,
  output logic [pps_pkg::TIME_W-1:0]           out_turnaround_ticks,
  output logic                                 out_last_done
);
  import pps_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  loaded_r, loaded_nxt;
  logic [CNT_W-1:0]  done_r, done_nxt;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;

  logic              mem_we;
  logic [TASK_W-1:0] mem_waddr;
  task_rec_t         mem_wdata;
  task_rec_t         mem_rdata;
  scan_ctl_t         scan_ctl;
  pick_t             pick;

  logic              load_acc;
  logic [BURST_W-1:0] burst_clamped;
  task_rec_t         charged;
  logic              finish;
  logic [TIME_W-1:0] tick_end;
  logic [TIME_W-1:0] tat;

  logic              strobe_r, strobe_nxt;
  logic [OUT_IDX_W-1:0] idx_out_r;
  logic [TIME_W-1:0] wait_out_r, tat_out_r;
  logic              last_out_r;

  assign load_acc      = start && (state_r == ST_IDLE);
  assign burst_clamped = (in_burst_ticks == '0) ? BURST_W'(1) : in_burst_ticks;

  always_comb begin
    charged        = pick.rec;
    charged.remain = pick.rec.remain - BURST_W'(1);
  end

  assign finish   = pick.found && (charged.remain == '0);
  assign tick_end = time_r + TIME_W'(1);
  assign tat      = tick_end - TIME_W'(pick.rec.arrival);

  always_comb begin
    scan_ctl.clear = (state_r == ST_SCAN) && (scan_r == '0);
    scan_ctl.cmp   = (state_r == ST_SCAN) && (scan_r != '0);
    scan_ctl.idx   = TASK_W'(scan_r - CNT_W'(1));
  end

  always_comb begin
    state_nxt  = state_r;
    loaded_nxt = loaded_r;
    done_nxt   = done_r;
    scan_nxt   = scan_r;
    time_nxt   = time_r;
    strobe_nxt = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = TASK_W'(loaded_r);
    mem_wdata  = '{burst: burst_clamped, prio: in_task_priority,
                   arrival: in_arrival_tick, remain: burst_clamped};
    unique case (state_r)
      ST_IDLE: begin
        if (load_acc) begin
          if (loaded_r < CNT_W'(MAX_TASKS)) begin
            mem_we     = 1'b1;
            loaded_nxt = loaded_r + CNT_W'(1);
          end
          if (in_last_task) begin
            state_nxt = ST_SCAN;
            scan_nxt  = '0;
            time_nxt  = '0;
            done_nxt  = '0;
          end
        end
      end
      ST_SCAN: begin
        scan_nxt = scan_r + CNT_W'(1);
        if (scan_r == loaded_r) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        scan_nxt  = '0;
        state_nxt = ST_SCAN;
        if (pick.found) begin
          mem_we    = 1'b1;
          mem_waddr = pick.idx;
          mem_wdata = charged;
          time_nxt  = tick_end;
          if (finish) begin
            strobe_nxt = 1'b1;
            done_nxt   = done_r + CNT_W'(1);
          end
        end else begin
          time_nxt = TIME_W'(pick.min_arrival);
        end
        if (finish && (done_r + CNT_W'(1) == loaded_r)) begin
          state_nxt  = ST_IDLE;
          loaded_nxt = '0;
          done_nxt   = '0;
          time_nxt   = '0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      loaded_r <= '0;
      done_r   <= '0;
      scan_r   <= '0;
      time_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      loaded_r <= loaded_nxt;
      done_r   <= done_nxt;
      scan_r   <= scan_nxt;
      time_r   <= time_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (strobe_nxt) begin
      idx_out_r  <= OUT_IDX_W'(pick.idx);
      tat_out_r  <= tat;
      wait_out_r <= tat - TIME_W'(pick.rec.burst);
      last_out_r <= (done_r + CNT_W'(1) == loaded_r);
    end
  end

  pps_task_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (TASK_W'(scan_r)),
    .rdata (mem_rdata)
  );

  pps_pick u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (scan_ctl),
    .rec      (mem_rdata),
    .sim_time (time_r),
    .pick     (pick)
  );

  assign busy                 = (state_r != ST_IDLE);
  assign out_strobe           = strobe_r;
  assign out_task_index       = idx_out_r;
  assign out_wait_ticks       = wait_out_r;
  assign out_turnaround_ticks = tat_out_r;
  assign out_last_done        = last_out_r;

  a_strobe_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == ST_UPDATE))
    else $error("result without a write-back");

  a_done_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (done_r < loaded_r))
    else $error("completion count overran the loaded set");

  a_loaded_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= CNT_W'(MAX_TASKS))
    else $error("task table overfilled");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_done) |-> (state_r == ST_IDLE))
    else $error("run continued after final completion");

endmodule

`default_nettype wire
